### rtl/si_pkg.sv
// Shared types, widths and helpers for the segment intersection block.
// Used by every module and interface of the block; depends on nothing.
package si_pkg;

   // Coordinate and fixed-point formats.
   localparam int CoordW   = 16;
   localparam int FracBits = 8;
   localparam int OutW     = 24;

   // Derived arithmetic widths.
   localparam int DiffW  = CoordW + 1;             // difference of two coordinates
   localparam int ProdW  = 2 * DiffW;              // product of two differences
   localparam int CrossW = ProdW + 1;              // cross product
   localparam int MagW   = CrossW - 1;             // magnitude of a cross product
   localparam int DenW   = MagW + 1;               // |d1| + |d2|
   localparam int SpanW  = CoordW;                 // magnitude of an endpoint difference
   localparam int LoW    = MagW / 2;               // low slice of the multiplier split
   localparam int HiW    = MagW - LoW;             // high slice of the multiplier split
   localparam int PpW    = SpanW + HiW;            // partial product width
   localparam int NumW   = SpanW + MagW + FracBits;// dividend width
   localparam int QuoW   = CoordW + FracBits;      // quotient magnitude width
   localparam int RemW   = DenW + QuoW;            // divider remainder width
   localparam int SumW   = CoordW + FracBits + 2;  // final point before truncation

   // Queue between the front and back parts.
   localparam int QueueDepth = 4;
   localparam int QueueAw    = $clog2(QueueDepth);

   typedef logic signed [CoordW-1:0] coord_type;
   typedef logic signed [DiffW-1:0]  diff_type;
   typedef logic signed [CrossW-1:0] cross_type;

   // One classified pair handed from the front part to the back part.
   typedef struct packed {
      logic      hit;
      coord_type cx;
      coord_type cy;
      coord_type dx;
      coord_type dy;
      cross_type d1;
      cross_type d2;
   } job_type;

   // Side information that travels beside the divider stages.
   typedef struct packed {
      logic      hit;
      logic      neg_x;
      logic      neg_y;
      coord_type cx;
      coord_type cy;
   } side_type;

   // Signed difference of two coordinates, one bit wider.
   function automatic diff_type coord_diff(input coord_type a, input coord_type b);
      diff_type ea;
      diff_type eb;
      ea = {a[CoordW-1], a};
      eb = {b[CoordW-1], b};
      return ea - eb;
   endfunction

   // Strictly positive test for a cross product.
   function automatic logic is_pos(input cross_type v);
      return !v[CrossW-1] && (v != '0);
   endfunction

endpackage

### rtl/si_req_if.sv
// Input channel: one beat carries the endpoints of both segments.
// Depends on si_pkg for the coordinate type.
interface si_req_if import si_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type seg_a_x0;
   coord_type seg_a_y0;
   coord_type seg_a_x1;
   coord_type seg_a_y1;
   coord_type seg_b_x0;
   coord_type seg_b_y0;
   coord_type seg_b_x1;
   coord_type seg_b_y1;

   modport source (output valid, seg_a_x0, seg_a_y0, seg_a_x1, seg_a_y1,
                   seg_b_x0, seg_b_y0, seg_b_x1, seg_b_y1, input ready);
   modport sink   (input valid, seg_a_x0, seg_a_y0, seg_a_x1, seg_a_y1,
                   seg_b_x0, seg_b_y0, seg_b_x1, seg_b_y1, output ready);
endinterface

### rtl/si_rsp_if.sv
// Result channel: one beat carries the crossing flag and the point.
// Depends on si_pkg for the output width.
interface si_rsp_if import si_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   crosses;
   logic signed [OutW-1:0] cross_x;
   logic signed [OutW-1:0] cross_y;

   modport source (output valid, crosses, cross_x, cross_y, input ready);
   modport sink   (input valid, crosses, cross_x, cross_y, output ready);
endinterface

### rtl/segment_intersection.sv
// Top level of the segment intersection block.
// Depends on si_pkg, si_req_if, si_rsp_if, si_front, si_queue and si_back.

// The block accepts one pair of segments per clock cycle while the front is not
// held by a full queue, and returns one result beat per pair, in order. A beat
// passes 2 registers in the front part (products, then classification), the
// queue, the span and dividend setup registers B0, B1 and B2, the stages of the
// pipelined divider that produce the 24 quotient bits, and the output register.
// The sustained rate of one pair per cycle while results are taken is set by the
// fully pipelined divider; the queue lets the front keep accepting while the
// result side is briefly held. cross_x and cross_y carry 8 fraction bits, are
// truncated toward zero, and are zero when the segments do not strictly cross.
module segment_intersection import si_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   si_req_if.sink   req,
   si_rsp_if.source rsp
);

   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_nonempty;
   job_type q_job;
   job_type q_head;

   si_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (q_job)
   );

   si_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .full     (q_full),
      .nonempty (q_nonempty),
      .head     (q_head)
   );

   si_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp        (rsp)
   );

endmodule

### rtl/si_front.sv
// Front part: computes the four cross products and classifies the pair.
// Depends on si_pkg and si_req_if; feeds si_queue.
module si_front import si_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   si_req_if.sink   req,
   input  logic     q_full,
   output logic     q_push,
   output job_type  q_job
);

   logic                    adv;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s2_valid_ff, s2_valid_in;
   logic signed [ProdW-1:0] prod_ff [8];
   logic signed [ProdW-1:0] prod_in [8];
   coord_type               cx_ff, cy_ff, dx_ff, dy_ff;
   job_type                 job_ff, job_in;
   diff_type                abx, aby, acx, acy, adx, ady;
   diff_type                cdx, cdy, cax, cay, cbx, cby;
   cross_type               d1, d2, d3, d4;

   // Both stages move together; the second one drains into the queue.
   assign adv       = !s2_valid_ff || !q_full;
   assign req.ready = adv;
   assign q_push    = s2_valid_ff && !q_full;
   assign q_job     = job_ff;

   // Endpoint differences and the eight products.
   always_comb begin
      abx = coord_diff(req.seg_a_x1, req.seg_a_x0);
      aby = coord_diff(req.seg_a_y1, req.seg_a_y0);
      acx = coord_diff(req.seg_b_x0, req.seg_a_x0);
      acy = coord_diff(req.seg_b_y0, req.seg_a_y0);
      adx = coord_diff(req.seg_b_x1, req.seg_a_x0);
      ady = coord_diff(req.seg_b_y1, req.seg_a_y0);
      cdx = coord_diff(req.seg_b_x1, req.seg_b_x0);
      cdy = coord_diff(req.seg_b_y1, req.seg_b_y0);
      cax = coord_diff(req.seg_a_x0, req.seg_b_x0);
      cay = coord_diff(req.seg_a_y0, req.seg_b_y0);
      cbx = coord_diff(req.seg_a_x1, req.seg_b_x0);
      cby = coord_diff(req.seg_a_y1, req.seg_b_y0);
      prod_in[0] = abx * acy;
      prod_in[1] = aby * acx;
      prod_in[2] = abx * ady;
      prod_in[3] = aby * adx;
      prod_in[4] = cdx * cay;
      prod_in[5] = cdy * cax;
      prod_in[6] = cdx * cby;
      prod_in[7] = cdy * cbx;
      s1_valid_in = req.valid;
   end

   // Cross products and the strict opposite-side test.
   always_comb begin
      d1 = {prod_ff[0][ProdW-1], prod_ff[0]} - {prod_ff[1][ProdW-1], prod_ff[1]};
      d2 = {prod_ff[2][ProdW-1], prod_ff[2]} - {prod_ff[3][ProdW-1], prod_ff[3]};
      d3 = {prod_ff[4][ProdW-1], prod_ff[4]} - {prod_ff[5][ProdW-1], prod_ff[5]};
      d4 = {prod_ff[6][ProdW-1], prod_ff[6]} - {prod_ff[7][ProdW-1], prod_ff[7]};
      job_in.hit = ((is_pos(d1) && d2[CrossW-1]) || (d1[CrossW-1] && is_pos(d2))) &&
                   ((is_pos(d3) && d4[CrossW-1]) || (d3[CrossW-1] && is_pos(d4)));
      job_in.cx  = cx_ff;
      job_in.cy  = cy_ff;
      job_in.dx  = dx_ff;
      job_in.dy  = dy_ff;
      job_in.d1  = d1;
      job_in.d2  = d2;
      s2_valid_in = s1_valid_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         cx_ff   <= req.seg_b_x0;
         cy_ff   <= req.seg_b_y0;
         dx_ff   <= req.seg_b_x1;
         dy_ff   <= req.seg_b_y1;
         job_ff  <= job_in;
      end
   end

endmodule

### rtl/si_queue.sv
// Short queue that decouples the classifying front from the arithmetic back.
// Depends on si_pkg for the job type and depth.
module si_queue import si_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    nonempty,
   output job_type head
);

   job_type              mem_ff [QueueDepth];
   logic [QueueAw-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QueueAw:0]     cnt_ff, cnt_in;

   assign full     = (cnt_ff == (QueueAw+1)'(QueueDepth));
   assign nonempty = (cnt_ff != '0);
   assign head     = mem_ff[rd_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

### rtl/si_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on si_pkg for the dividend, divisor and quotient widths.
module si_div import si_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [NumW-1:0]   num,
   input  logic [DenW-1:0]   den,
   output logic [QuoW-1:0]   quo,
   output logic              rem_nz
);

   logic [RemW-1:0] rem_ff [QuoW];
   logic [DenW-1:0] den_ff [QuoW];
   logic [QuoW-1:0] quo_ff [QuoW];

   assign quo    = quo_ff[QuoW-1];
   assign rem_nz = (rem_ff[QuoW-1] != '0);

   for (genvar k = 0; k < QuoW; k++) begin : g_stage
      logic [RemW-1:0] rem_cur;
      logic [DenW-1:0] den_cur;
      logic [QuoW-1:0] quo_cur;
      logic [RemW-1:0] trial;
      logic [RemW-1:0] rem_in;
      logic [QuoW-1:0] quo_in;

      // Stage k tries the divisor shifted to the next quotient bit.
      always_comb begin
         if (k == 0) begin
            rem_cur = RemW'(num);
            den_cur = den;
            quo_cur = '0;
         end else begin
            rem_cur = rem_ff[(k == 0) ? 0 : k-1];
            den_cur = den_ff[(k == 0) ? 0 : k-1];
            quo_cur = quo_ff[(k == 0) ? 0 : k-1];
         end
         trial = RemW'(den_cur) << (QuoW-1-k);
         if (rem_cur >= trial) begin
            rem_in = rem_cur - trial;
            quo_in = {quo_cur[QuoW-2:0], 1'b1};
         end else begin
            rem_in = rem_cur;
            quo_in = {quo_cur[QuoW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_cur;
            quo_ff[k] <= quo_in;
         end
      end
   end

endmodule

### rtl/si_back.sv
// Back part: forms the interpolation dividend, divides and rounds toward zero.
// Depends on si_pkg, si_div and si_rsp_if; takes jobs from si_queue.
module si_back import si_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_nonempty,
   input  job_type  q_head,
   output logic     q_pop,
   si_rsp_if.source rsp
);

   logic                   en;
   // Stage B0: magnitudes.
   logic                   b0_valid_ff;
   side_type               b0_side_ff, b0_side_in;
   logic [SpanW-1:0]       b0_ex_ff, b0_ex_in, b0_ey_ff, b0_ey_in;
   logic [MagW-1:0]        b0_mag_ff, b0_mag_in;
   logic [DenW-1:0]        b0_den_ff, b0_den_in;
   // Stage B1: partial products.
   logic                   b1_valid_ff;
   side_type               b1_side_ff;
   logic [DenW-1:0]        b1_den_ff;
   logic [PpW-1:0]         b1_xlo_ff, b1_xhi_ff, b1_ylo_ff, b1_yhi_ff;
   // Stage B2: dividends.
   logic                   b2_valid_ff;
   side_type               b2_side_ff;
   logic [DenW-1:0]        b2_den_ff;
   logic [NumW-1:0]        b2_numx_ff, b2_numx_in, b2_numy_ff, b2_numy_in;
   // Divider side pipeline.
   logic                   dv_valid_ff [QuoW];
   side_type               dv_side_ff  [QuoW];
   logic [QuoW-1:0]        quo_x, quo_y;
   logic                   nz_x, nz_y;
   // Output register.
   logic                   out_valid_ff;
   logic                   out_hit_ff;
   logic signed [OutW-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   diff_type               ex, ey;
   cross_type              d1, d2;
   logic [CrossW-1:0]      m1, m2;
   side_type               last;

   // The whole back pipeline stalls only when a finished beat is not taken.
   assign en    = !out_valid_ff || rsp.ready;
   assign q_pop = en && q_nonempty;

   // Magnitudes and signs of the spans and cross products.
   always_comb begin
      ex = coord_diff(q_head.dx, q_head.cx);
      ey = coord_diff(q_head.dy, q_head.cy);
      d1 = q_head.d1;
      d2 = q_head.d2;
      b0_ex_in = ex[DiffW-1] ? SpanW'(-ex) : SpanW'(ex);
      b0_ey_in = ey[DiffW-1] ? SpanW'(-ey) : SpanW'(ey);
      m1 = d1[CrossW-1] ? -d1 : d1;
      m2 = d2[CrossW-1] ? -d2 : d2;
      b0_mag_in = m1[MagW-1:0];
      // Crossing cross products have opposite signs, so |d1 - d2| = |d1| + |d2|.
      b0_den_in = DenW'(m1[MagW-1:0]) + DenW'(m2[MagW-1:0]);
      b0_side_in.hit   = q_head.hit;
      b0_side_in.neg_x = ex[DiffW-1];
      b0_side_in.neg_y = ey[DiffW-1];
      b0_side_in.cx    = q_head.cx;
      b0_side_in.cy    = q_head.cy;
   end

   // Dividend: (|e| * |d1|) scaled by the fraction bits.
   always_comb begin
      b2_numx_in = ((NumW'(b1_xhi_ff) << LoW) + NumW'(b1_xlo_ff)) << FracBits;
      b2_numy_in = ((NumW'(b1_yhi_ff) << LoW) + NumW'(b1_ylo_ff)) << FracBits;
   end

   si_div u_div_x (
      .clock  (clock),
      .en     (en),
      .num    (b2_numx_ff),
      .den    (b2_den_ff),
      .quo    (quo_x),
      .rem_nz (nz_x)
   );

   si_div u_div_y (
      .clock  (clock),
      .en     (en),
      .num    (b2_numy_ff),
      .den    (b2_den_ff),
      .quo    (quo_y),
      .rem_nz (nz_y)
   );

   // Fold the quotient into the start point and truncate toward zero.
   function automatic logic signed [OutW-1:0] place(input coord_type c,
                                                     input logic [QuoW-1:0] q,
                                                     input logic neg,
                                                     input logic nz,
                                                     input logic hit);
      logic signed [SumW-1:0] base;
      logic signed [SumW-1:0] qs;
      logic signed [SumW-1:0] s;
      base = SumW'(c) <<< FracBits;
      qs   = neg ? -SumW'(q) : SumW'(q);
      s    = base + qs;
      if (nz && neg && !s[SumW-1] && (s != '0)) begin
         s = s - SumW'(1);
      end else if (nz && !neg && s[SumW-1]) begin
         s = s + SumW'(1);
      end
      return hit ? s[OutW-1:0] : '0;
   endfunction

   always_comb begin
      last     = dv_side_ff[QuoW-1];
      out_x_in = place(last.cx, quo_x, last.neg_x, nz_x, last.hit);
      out_y_in = place(last.cy, quo_y, last.neg_y, nz_y, last.hit);
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.crosses = out_hit_ff;
   assign rsp.cross_x = out_x_ff;
   assign rsp.cross_y = out_y_ff;

   // Valid bits along the back pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff  <= 1'b0;
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         dv_valid_ff  <= '{default: 1'b0};
         out_valid_ff <= 1'b0;
      end else if (en) begin
         b0_valid_ff    <= q_nonempty;
         b1_valid_ff    <= b0_valid_ff;
         b2_valid_ff    <= b1_valid_ff;
         dv_valid_ff[0] <= b2_valid_ff;
         for (int i = 1; i < QuoW; i++) begin
            dv_valid_ff[i] <= dv_valid_ff[i-1];
         end
         out_valid_ff   <= dv_valid_ff[QuoW-1];
      end
   end

   // Payload along the back pipeline.
   always_ff @(posedge clock) begin
      if (en) begin
         b0_side_ff <= b0_side_in;
         b0_ex_ff   <= b0_ex_in;
         b0_ey_ff   <= b0_ey_in;
         b0_mag_ff  <= b0_mag_in;
         b0_den_ff  <= b0_den_in;
         b1_side_ff <= b0_side_ff;
         b1_den_ff  <= b0_den_ff;
         b1_xlo_ff  <= PpW'(b0_ex_ff) * PpW'(b0_mag_ff[LoW-1:0]);
         b1_xhi_ff  <= PpW'(b0_ex_ff) * PpW'(b0_mag_ff[MagW-1:LoW]);
         b1_ylo_ff  <= PpW'(b0_ey_ff) * PpW'(b0_mag_ff[LoW-1:0]);
         b1_yhi_ff  <= PpW'(b0_ey_ff) * PpW'(b0_mag_ff[MagW-1:LoW]);
         b2_side_ff <= b1_side_ff;
         b2_den_ff  <= b1_den_ff;
         b2_numx_ff <= b2_numx_in;
         b2_numy_ff <= b2_numy_in;
         dv_side_ff[0] <= b2_side_ff;
         for (int i = 1; i < QuoW; i++) begin
            dv_side_ff[i] <= dv_side_ff[i-1];
         end
         out_hit_ff <= last.hit;
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
      end
   end

endmodule
